@@ hdl/yuvesc_pkg.sv @@
package yuvesc_pkg;

    // one UYVY macropixel, packed U:Y0:V:Y1
    typedef struct packed {
        logic [7:0] chroma_u;
        logic [7:0] luma_first;
        logic [7:0] chroma_v;
        logic [7:0] luma_second;
    } pix_t;

    typedef struct packed {
        logic [7:0]  seg_code;
        logic [17:0] edge_total;
        logic        frame_last;
    } res_t;

    // one line store entry: row above (prev) and the row above that (prev2)
    typedef struct packed {
        pix_t prev;
        pix_t prev2;
    } line_t;

    localparam int GRAD_W = 18;
    localparam int DIM_W  = 9;
    localparam int THR_W  = 18;

    typedef struct packed {
        logic [DIM_W-1:0] row_mp;
        logic [DIM_W-1:0] frame_rows;
        logic [THR_W-1:0] edge_thr;
        logic             restart;
    } cfg_t;

    localparam logic [1:0] REG_ROW_MP     = 2'd0;
    localparam logic [1:0] REG_FRAME_ROWS = 2'd1;
    localparam logic [1:0] REG_EDGE_THR   = 2'd2;

    localparam logic [DIM_W-1:0] ROW_MP_RESET     = 9'd160;
    localparam logic [DIM_W-1:0] FRAME_ROWS_RESET = 9'd240;
    localparam logic [DIM_W-1:0] MIN_DIM          = 9'd3;

endpackage

@@ hdl/yuv_edge_segment_coder_core.sv @@
// Channel  | Signals                          | Beat
// ---------+----------------------------------+-------------------------------------
// pix      | pix_valid, pix_ready, pix        | one UYVY macropixel, raster order
// code     | code_valid, code_ready, code     | one code byte, count, last flag
// apb      | psel, penable, pwrite, paddr,    | register write/read, 4-byte stride
//          | pwdata, prdata, pready           |
//
// Sustains one pix beat per cycle while code_ready keeps up; a code beat passes stage A,
// stage B and the output register. The rate is set by the line store: one synchronous
// 64-bit memory, two read ports and a write port, read on accept, written back on a_go.
// Reset clears positions, count and valids only; the line store is not cleared
// and stale entries read in rows 0 and 1 never reach the code byte or the count.
// With a code beat stalled, pix_ready drops once stage A is full behind a stage B beat with a code.
module yuv_edge_segment_coder_core
    import yuvesc_pkg::*;
#(
    parameter int MAX_ROW_MACROPIXELS = 320
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  pix_t        pix,
    output logic        code_valid,
    input  logic        code_ready,
    output res_t        code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = $clog2(MAX_ROW_MACROPIXELS);
    localparam int CNT_W  = (ADDR_W + 1 > DIM_W) ? ADDR_W + 1 : DIM_W;

    cfg_t cfg;

    // ---------------- configuration ----------------
    yuvesc_regs #(
        .MAX_ROW_MACROPIXELS(MAX_ROW_MACROPIXELS)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    // ---------------- input position ----------------
    logic [ADDR_W-1:0] col_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [CNT_W-1:0]  col_ext;
    logic [CNT_W-1:0]  col_nx;
    logic [CNT_W-1:0]  m_ext;
    logic              col_end;
    logic              row_end;
    logic              accept;
    logic [ADDR_W-1:0] rd_addr_b;

    assign col_ext = CNT_W'(col_reg);
    assign col_nx  = col_ext + 1'b1;
    assign m_ext   = CNT_W'(cfg.row_mp);
    assign col_end = (col_nx == m_ext);
    assign row_end = ((row_reg + 1'b1) == cfg.frame_rows);
    assign accept  = pix_valid & pix_ready;
    // right neighbor; unused on the last column
    assign rd_addr_b = col_end ? '0 : col_nx[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_nx[ADDR_W-1:0];
            end
        end
    end

    // ---------------- stage A: line store read data ----------------
    logic              a_valid_reg;
    pix_t              a_word_reg;
    logic [ADDR_W-1:0] a_col_reg;
    logic              a_has_out_reg;
    logic              a_interior_reg;
    logic              a_last_reg;
    logic              a_go;
    line_t             rd_a;
    pix_t              rd_b;
    line_t             wr_line;
    pix_t              left_reg;
    logic [GRAD_W-1:0] gv;
    logic [GRAD_W-1:0] gh;

    // ---------------- stage B: gradients ----------------
    logic              b_valid_reg;
    logic              b_has_out_reg;
    logic              b_interior_reg;
    logic              b_last_reg;
    logic [GRAD_W-1:0] b_gv_reg;
    logic [GRAD_W-1:0] b_gh_reg;
    logic [5:0]        b_color_reg;
    logic              b_go;

    // ---------------- output register ----------------
    logic              code_valid_reg;
    res_t              code_reg;
    logic [17:0]       edge_cnt_reg;
    logic [17:0]       cnt_inc;
    logic              flag_v;
    logic              flag_h;
    logic              hit;
    logic [7:0]        seg;

    assign b_go      = b_valid_reg & (!b_has_out_reg | !code_valid_reg | code_ready);
    assign a_go      = a_valid_reg & (!b_valid_reg | b_go);
    assign pix_ready = !a_valid_reg | a_go;

    yuvesc_line_store #(
        .DEPTH (MAX_ROW_MACROPIXELS),
        .ADDR_W(ADDR_W)
    ) u_line (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr_a(col_reg),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd_a),
        .rd_data_b(rd_b),
        .wr_en    (a_go),
        .wr_addr  (a_col_reg),
        .wr_data  (wr_line)
    );

    // shift the column down one row
    assign wr_line.prev  = a_word_reg;
    assign wr_line.prev2 = rd_a.prev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_word_reg     <= pix;
            a_col_reg      <= col_reg;
            a_has_out_reg  <= (row_reg != '0);
            a_interior_reg <= (col_reg != '0) && !col_end && (row_reg >= 9'd2);
            a_last_reg     <= col_end && row_end;
        end
    end

    // vertical: below (this beat) against above; horizontal: right against left
    yuvesc_grad u_grad_v (
        .a   (a_word_reg),
        .b   (rd_a.prev2),
        .grad(gv)
    );

    yuvesc_grad u_grad_h (
        .a   (rd_b),
        .b   (left_reg),
        .grad(gh)
    );

    // this column's center is the next column's left neighbor
    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            left_reg       <= rd_a.prev;
            b_has_out_reg  <= a_has_out_reg;
            b_interior_reg <= a_interior_reg;
            b_last_reg     <= a_last_reg;
            b_gv_reg       <= gv;
            b_gh_reg       <= gh;
            b_color_reg    <= {rd_a.prev.chroma_u[7:5], rd_a.prev.chroma_v[7:5]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!b_valid_reg | b_go)
        begin
            b_valid_reg <= a_go;
        end
    end

    assign flag_v  = (b_gv_reg > cfg.edge_thr);
    assign flag_h  = (b_gh_reg > cfg.edge_thr);
    assign hit     = b_interior_reg & (flag_v | flag_h);
    assign cnt_inc = edge_cnt_reg + {17'd0, hit};
    assign seg     = b_interior_reg ? {flag_v, flag_h, b_color_reg} : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cnt_reg   <= '0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.restart)
            begin
                edge_cnt_reg <= '0;
            end
            else if (b_go)
            begin
                edge_cnt_reg <= b_last_reg ? '0 : cnt_inc;
            end

            if (b_go && b_has_out_reg)
            begin
                code_valid_reg <= 1'b1;
            end
            else if (code_ready)
            begin
                code_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go && b_has_out_reg)
        begin
            code_reg.seg_code   <= seg;
            code_reg.edge_total <= cnt_inc;
            code_reg.frame_last <= b_last_reg;
        end
    end

    assign code_valid = code_valid_reg;
    assign code       = code_reg;

    // ---------------- assertions ----------------
    // write-back never lands on a column being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_go && accept) |-> (a_col_reg != col_reg && a_col_reg != rd_addr_b))
        else $error("line store write collides with read");

    // count restarts after the last beat of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_go && b_has_out_reg && b_last_reg && !cfg.restart) |=> (edge_cnt_reg == '0))
        else $error("edge count not cleared at frame end");

    // input column stays inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        col_ext < m_ext)
        else $error("column position beyond row width");

endmodule

@@ hdl/yuvesc_regs.sv @@
module yuvesc_regs
    import yuvesc_pkg::*;
#(
    parameter int MAX_ROW_MACROPIXELS = 320
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    localparam int MP_CAP = (MAX_ROW_MACROPIXELS > 511) ? 511 : MAX_ROW_MACROPIXELS;
    localparam logic [DIM_W-1:0] MP_MAX = DIM_W'(MP_CAP);

    logic [DIM_W-1:0] row_mp_reg;
    logic [DIM_W-1:0] frame_rows_reg;
    logic [THR_W-1:0] edge_thr_reg;
    logic             wr;
    logic [1:0]       idx;
    logic [DIM_W-1:0] wr_dim;
    logic [DIM_W-1:0] mp_sat;
    logic [DIM_W-1:0] rows_sat;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[3:2];
    assign wr_dim = pwdata[DIM_W-1:0];

    always_comb
    begin
        mp_sat   = wr_dim;
        rows_sat = wr_dim;
        if (wr_dim < MIN_DIM)
        begin
            mp_sat   = MIN_DIM;
            rows_sat = MIN_DIM;
        end
        else if (wr_dim > MP_MAX)
        begin
            mp_sat = MP_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_mp_reg     <= ROW_MP_RESET;
            frame_rows_reg <= FRAME_ROWS_RESET;
            edge_thr_reg   <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_ROW_MP:     row_mp_reg     <= mp_sat;
                REG_FRAME_ROWS: frame_rows_reg <= rows_sat;
                REG_EDGE_THR:   edge_thr_reg   <= pwdata[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ROW_MP:     prdata = 32'(row_mp_reg);
            REG_FRAME_ROWS: prdata = 32'(frame_rows_reg);
            REG_EDGE_THR:   prdata = 32'(edge_thr_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.row_mp     = row_mp_reg;
    assign cfg.frame_rows = frame_rows_reg;
    assign cfg.edge_thr   = edge_thr_reg;
    // geometry write restarts the frame
    assign cfg.restart    = wr && (idx inside {REG_ROW_MP, REG_FRAME_ROWS});

endmodule

@@ hdl/yuvesc_line_store.sv @@
module yuvesc_line_store
    import yuvesc_pkg::*;
#(
    parameter int DEPTH  = 320,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output line_t             rd_data_a,
    output pix_t              rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  line_t             wr_data
);

    line_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // port b only needs the row above
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b].prev;
        end
    end

endmodule

@@ hdl/yuvesc_grad.sv @@
module yuvesc_grad
    import yuvesc_pkg::*;
(
    input  pix_t              a,
    input  pix_t              b,
    output logic [GRAD_W-1:0] grad
);

    logic [8:0]         sum_a;
    logic [8:0]         sum_b;
    logic signed [9:0]  dy;
    logic signed [8:0]  du;
    logic signed [8:0]  dv;
    logic signed [19:0] dy_sq;
    logic signed [17:0] du_sq;
    logic signed [17:0] dv_sq;

    assign sum_a = {1'b0, a.luma_first} + {1'b0, a.luma_second};
    assign sum_b = {1'b0, b.luma_first} + {1'b0, b.luma_second};
    assign dy    = $signed({1'b0, sum_a}) - $signed({1'b0, sum_b});
    assign du    = $signed({1'b0, a.chroma_u}) - $signed({1'b0, b.chroma_u});
    assign dv    = $signed({1'b0, a.chroma_v}) - $signed({1'b0, b.chroma_v});

    assign dy_sq = dy * dy;
    assign du_sq = du * du;
    assign dv_sq = dv * dv;

    // luma term is (dY0+dY1)^2 / 4, at most 16 bits
    assign grad = {2'b00, dy_sq[17:2]} + {2'b00, du_sq[15:0]} + {2'b00, dv_sq[15:0]};

endmodule
